// File: design/efrf_pkg.sv
// Package with shared types, constants and functions of the Ethernet receive filter.
`default_nettype none

package efrf_pkg;

    localparam int unsigned C_MAX_FRAME = 65535;
    localparam int unsigned C_MIN_FRAME = 18;
    localparam logic [31:0] C_CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] C_CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [7:0]  C_BCAST_BYTE = 8'hFF;

    localparam logic [15:0] C_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] C_TYPE_ARP  = 16'h0806;
    localparam logic [15:0] C_TYPE_RARP = 16'h8035;
    localparam logic [15:0] C_TYPE_SNMP = 16'h814C;
    localparam logic [15:0] C_TYPE_IPX  = 16'h8137;
    localparam logic [15:0] C_TYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] C_TYPE_PPP  = 16'h880B;

    typedef enum logic [1:0] {
        ST_ACCEPTED    = 2'd0,
        ST_ADDR_MISS   = 2'd1,
        ST_CRC_ERROR   = 2'd2,
        ST_LENGTH_ERR  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PC_OTHER = 3'd0,
        PC_IPV4  = 3'd1,
        PC_ARP   = 3'd2,
        PC_RARP  = 3'd3,
        PC_SNMP  = 3'd4,
        PC_IPX   = 3'd5,
        PC_IPV6  = 3'd6,
        PC_PPP   = 3'd7
    } t_proto;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic [15:0] frame_length;
        t_proto      protocol_class;
        logic [15:0] ether_type;
        logic        is_broadcast;
        t_status     status;
    } t_result;

    // One entry of the byte-wise reflected CRC-32 table.
    function automatic logic [31:0] crc_table(input logic [7:0] idx);
        logic [31:0] c;
        c = {24'd0, idx};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ C_CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        return crc_table(crc[7:0] ^ b) ^ (crc >> 8);
    endfunction

    function automatic t_proto class_of(input logic [15:0] t);
        t_proto p;
        case (t)
            C_TYPE_IPV4: p = PC_IPV4;
            C_TYPE_ARP:  p = PC_ARP;
            C_TYPE_RARP: p = PC_RARP;
            C_TYPE_SNMP: p = PC_SNMP;
            C_TYPE_IPX:  p = PC_IPX;
            C_TYPE_IPV6: p = PC_IPV6;
            C_TYPE_PPP:  p = PC_PPP;
            default:     p = PC_OTHER;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// File: design/efrf_in_stage.sv
// Input register stage that holds one received byte until the frame logic takes it.
`default_nettype none

module efrf_in_stage
    import efrf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    output t_in_item      o_item,
    input  wire logic     i_pop
);

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;
    logic     take;

    assign o_ready = !r_valid || i_pop;
    assign take    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: design/efrf_frame_proc.sv
// Per-frame address, type, length and CRC tracking with the result register.
`default_nettype none

module efrf_frame_proc
    import efrf_pkg::*;
#(
    parameter int unsigned P_MAX_FRAME = C_MAX_FRAME
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [47:0] i_cfg_wr_data,
    input  wire logic        i_valid,
    input  wire t_in_item    i_item,
    output logic             o_pop,
    output logic             o_res_valid,
    output t_result          o_result,
    input  wire logic        i_res_ready
);

    localparam logic [16:0] L_MAX_LEN = 17'(P_MAX_FRAME);
    localparam logic [15:0] L_MIN_LEN = 16'(C_MIN_FRAME);

    logic [47:0] r_station;
    logic [15:0] r_byte_count;
    logic [31:0] r_crc;
    logic [31:0] r_tail;
    logic        r_bcast_match;
    logic        r_sta_match;
    logic [15:0] r_type;
    logic        r_too_long;
    logic        r_out_valid;
    t_result     r_result;

    logic [15:0] n_byte_count;
    logic [31:0] n_crc;
    logic [31:0] n_tail;
    logic        n_bcast_match;
    logic        n_sta_match;
    logic [15:0] n_type;
    logic        n_too_long;
    logic        n_out_valid;
    t_result     n_result;

    logic        advance;
    logic [7:0]  sta_byte;
    logic [15:0] pos;

    assign pos         = r_byte_count;
    assign advance     = i_valid && (!i_item.last || !r_out_valid || i_res_ready);
    assign o_pop       = advance;
    assign o_res_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        case (pos[2:0])
            3'd0:    sta_byte = r_station[47:40];
            3'd1:    sta_byte = r_station[39:32];
            3'd2:    sta_byte = r_station[31:24];
            3'd3:    sta_byte = r_station[23:16];
            3'd4:    sta_byte = r_station[15:8];
            3'd5:    sta_byte = r_station[7:0];
            default: sta_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_byte_count  = r_byte_count;
        n_crc         = r_crc;
        n_tail        = r_tail;
        n_bcast_match = r_bcast_match;
        n_sta_match   = r_sta_match;
        n_type        = r_type;
        n_too_long    = r_too_long;
        n_out_valid   = r_out_valid && !i_res_ready;
        n_result      = r_result;

        if (advance) begin
            if (pos == 16'hFFFF) begin
                n_too_long = 1'b1;
            end else begin
                if (pos < 16'd6) begin
                    if (i_item.data != C_BCAST_BYTE) begin
                        n_bcast_match = 1'b0;
                    end
                    if (i_item.data != sta_byte) begin
                        n_sta_match = 1'b0;
                    end
                end else if (pos == 16'd12) begin
                    n_type = {i_item.data, 8'd0};
                end else if (pos == 16'd13) begin
                    n_type = {r_type[15:8], i_item.data};
                end
                if (pos >= L_MIN_LEN) begin
                    n_crc = crc_update(r_crc, r_tail[7:0]);
                end
                n_byte_count = pos + 16'd1;
            end
            n_tail = {i_item.data, r_tail[31:8]};

            if (i_item.last) begin
                n_out_valid                 = 1'b1;
                n_result.frame_length       = n_byte_count;
                n_result.is_broadcast       = n_bcast_match;
                n_result.ether_type         = n_type;
                n_result.protocol_class     = class_of(n_type);
                if (n_too_long || n_byte_count < L_MIN_LEN
                        || {1'b0, n_byte_count} > L_MAX_LEN) begin
                    n_result.status         = ST_LENGTH_ERR;
                    n_result.is_broadcast   = 1'b0;
                    n_result.ether_type     = 16'd0;
                    n_result.protocol_class = PC_OTHER;
                end else if (!n_bcast_match && !n_sta_match) begin
                    n_result.status = ST_ADDR_MISS;
                end else if ((n_crc ^ C_CRC_INIT) != n_tail) begin
                    n_result.status = ST_CRC_ERROR;
                end else begin
                    n_result.status = ST_ACCEPTED;
                end

                n_byte_count  = 16'd0;
                n_crc         = C_CRC_INIT;
                n_tail        = 32'd0;
                n_bcast_match = 1'b1;
                n_sta_match   = 1'b1;
                n_type        = 16'd0;
                n_too_long    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station     <= 48'd0;
            r_byte_count  <= 16'd0;
            r_crc         <= C_CRC_INIT;
            r_tail        <= 32'd0;
            r_bcast_match <= 1'b1;
            r_sta_match   <= 1'b1;
            r_type        <= 16'd0;
            r_too_long    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_station <= i_cfg_wr_data;
            end
            r_byte_count  <= n_byte_count;
            r_crc         <= n_crc;
            r_tail        <= n_tail;
            r_bcast_match <= n_bcast_match;
            r_sta_match   <= n_sta_match;
            r_type        <= n_type;
            r_too_long    <= n_too_long;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

endmodule

`default_nettype wire

// File: design/ethernet_frame_receive_filter.sv
// Top level of the Ethernet receive filter with destination, length and CRC-32 checks.
//
// Frames arrive one byte per transfer on the s_axis channel in wire order, with
// s_axis_tlast set on the final byte. Every frame yields one status transfer on
// the m_axis channel, and no other byte yields any output.
// The station address resets to zero; the user must write it through i_cfg_wr_en
// and i_cfg_wr_data only while no frame is in flight; the block does not enforce it.
// One byte is accepted per clock unless a last byte waits on a pending status. Each
// byte passes an input register and then the frame logic, whose per-byte CRC update
// is a single table lookup; a frame's status is captured in the output register
// when its last byte leaves the input register, and is then valid on m_axis.
// The output register holds a status while the sink stalls, and bytes keep
// flowing in behind it until the next frame's last byte reaches the frame logic;
// that byte then waits until the pending status has been taken.
// Reset is synchronous and active low. It clears both valid flags and all
// per-frame state, so the first byte after reset starts a new frame.
`default_nettype none

module ethernet_frame_receive_filter
    import efrf_pkg::*;
#(
    parameter int unsigned P_MAX_FRAME = C_MAX_FRAME
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [47:0] i_cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] status, [2] is_broadcast, [18:3] ether_type, [21:19] protocol_class,
    // [37:22] frame_length, [39:38] zero
    output logic [39:0]      m_axis_tdata
);

    t_in_item in_item;
    t_in_item stage_item;
    logic     stage_valid;
    logic     pop;
    t_result  result;

    assign in_item.data = s_axis_tdata;
    assign in_item.last = s_axis_tlast;

    efrf_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .o_item  (stage_item),
        .i_pop   (pop)
    );

    efrf_frame_proc #(
        .P_MAX_FRAME (P_MAX_FRAME)
    ) u_frame_proc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (stage_valid),
        .i_item        (stage_item),
        .o_pop         (pop),
        .o_res_valid   (m_axis_tvalid),
        .o_result      (result),
        .i_res_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, result};

endmodule

`default_nettype wire

// File: tb/ethernet_frame_receive_filter_check.sv
// Checker that predicts the status of every received frame and compares it with the output channel.
module ethernet_frame_receive_filter_check
    import efrf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [47:0] i_cfg_wr_data,
    input  wire logic        i_byte_tvalid,
    input  wire logic        i_byte_tready,
    input  wire logic [7:0]  i_byte_tdata,
    input  wire logic        i_byte_tlast,
    input  wire logic        i_status_tvalid,
    input  wire logic        i_status_tready,
    input  wire logic [39:0] i_status_tdata,
    output int unsigned      o_mismatches,
    output int unsigned      o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [47:0] station_mac;
    logic [15:0] byte_pos;
    logic [31:0] fcs_acc;
    logic [31:0] fcs_tail;
    logic        all_ones_dst;
    logic        station_dst;
    logic [15:0] type_field;
    logic        overlength;
    t_result     status_due[$];
    int unsigned mismatches;

    function automatic logic [31:0] fcs_next(logic [31:0] c, logic [7:0] b);
        c = c ^ {24'd0, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ C_CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic t_proto type_class(logic [15:0] t);
        case (t)
            C_TYPE_IPV4: return PC_IPV4;
            C_TYPE_ARP:  return PC_ARP;
            C_TYPE_RARP: return PC_RARP;
            C_TYPE_SNMP: return PC_SNMP;
            C_TYPE_IPX:  return PC_IPX;
            C_TYPE_IPV6: return PC_IPV6;
            C_TYPE_PPP:  return PC_PPP;
            default:     return PC_OTHER;
        endcase
    endfunction

    function automatic void restart_frame();
        byte_pos = '0;
        fcs_acc = C_CRC_INIT;
        fcs_tail = '0;
        all_ones_dst = 1'b1;
        station_dst = 1'b1;
        type_field = '0;
        overlength = 1'b0;
    endfunction

    function automatic void absorb_byte(logic [7:0] b, logic last);
        t_result r;
        if (byte_pos == 16'hFFFF) begin
            overlength = 1'b1;
        end else begin
            if (byte_pos < 6) begin
                if (b != C_BCAST_BYTE) all_ones_dst = 1'b0;
                if (b != station_mac[8 * (5 - int'(byte_pos)) +: 8]) station_dst = 1'b0;
            end else if (byte_pos == 12) begin
                type_field = {b, 8'h00};
            end else if (byte_pos == 13) begin
                type_field[7:0] = b;
            end
            if (byte_pos >= 18) fcs_acc = fcs_next(fcs_acc, fcs_tail[7:0]);
            byte_pos++;
        end
        fcs_tail = {b, fcs_tail[31:8]};
        if (last) begin
            r.frame_length = byte_pos;
            r.is_broadcast = all_ones_dst;
            r.ether_type = type_field;
            r.protocol_class = type_class(type_field);
            if (overlength || byte_pos < C_MIN_FRAME || byte_pos > C_MAX_FRAME) begin
                r.status = ST_LENGTH_ERR;
                r.is_broadcast = 1'b0;
                r.ether_type = '0;
                r.protocol_class = PC_OTHER;
            end else if (!all_ones_dst && !station_dst) begin
                r.status = ST_ADDR_MISS;
            end else if (~fcs_acc != fcs_tail) begin
                r.status = ST_CRC_ERROR;
            end else begin
                r.status = ST_ACCEPTED;
            end
            status_due.push_back(r);
            restart_frame();
        end
    endfunction

    function automatic void field_check(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    function automatic void compare_status(logic [39:0] d);
        t_result got;
        t_result want;
        got = d[37:0];
        if (status_due.size() == 0) begin
            $display("%0t ns: status transfer %h with none expected", $time, d);
            mismatches++;
            return;
        end
        want = status_due.pop_front();
        field_check("status", 16'(want.status), 16'(got.status));
        field_check("is_broadcast", 16'(want.is_broadcast), 16'(got.is_broadcast));
        field_check("ether_type", want.ether_type, got.ether_type);
        field_check("protocol_class", 16'(want.protocol_class), 16'(got.protocol_class));
        field_check("frame_length", want.frame_length, got.frame_length);
        field_check("padding", 16'h0000, {14'd0, d[39:38]});
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            station_mac = '0;
            restart_frame();
            status_due.delete();
        end else begin
            if (i_cfg_wr_en) station_mac = i_cfg_wr_data;
            if (i_status_tvalid && i_status_tready) compare_status(i_status_tdata);
            if (i_byte_tvalid && i_byte_tready) absorb_byte(i_byte_tdata, i_byte_tlast);
        end
        o_mismatches <= mismatches;
        o_outstanding <= status_due.size();
    end

endmodule

// File: tb/ethernet_frame_receive_filter_test.sv
// Top of the testbench that sends Ethernet frames through the receive filter and gives the verdict.
module ethernet_frame_receive_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import efrf_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [47:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = '0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    wire logic        s_ready;
    wire logic        m_valid;
    wire logic [39:0] m_data;
    int unsigned mismatches;
    int unsigned outstanding;

    logic [7:0]  frame_bytes[$];
    logic [47:0] station = '0;
    bit          src_fast = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned hold_req = 0;
    int unsigned hold_done = 0;
    logic [15:0] known_types[7] = '{C_TYPE_IPV4, C_TYPE_ARP, C_TYPE_RARP, C_TYPE_SNMP,
                                    C_TYPE_IPX, C_TYPE_IPV6, C_TYPE_PPP};

    always #5 i_clk = ~i_clk;

    ethernet_frame_receive_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    ethernet_frame_receive_filter_check filter_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_byte_tvalid   (s_valid),
        .i_byte_tready   (s_ready),
        .i_byte_tdata    (s_data),
        .i_byte_tlast    (s_last),
        .i_status_tvalid (m_valid),
        .i_status_tready (m_ready),
        .i_status_tdata  (m_data),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    function automatic logic [31:0] fcs_byte(logic [31:0] c, logic [7:0] b);
        c = c ^ {24'd0, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ C_CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void build_frame(logic [47:0] dst, logic [15:0] etype, int plen, bit bad_fcs);
        logic [31:0] fcs;
        logic [7:0]  b;
        frame_bytes.delete();
        fcs = C_CRC_INIT;
        for (int i = 0; i < 6; i++) frame_bytes.push_back(dst[8 * (5 - i) +: 8]);
        repeat (6) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(etype[15:8]);
        frame_bytes.push_back(etype[7:0]);
        repeat (plen) begin
            b = 8'($urandom);
            frame_bytes.push_back(b);
            fcs = fcs_byte(fcs, b);
        end
        fcs = ~fcs;
        if (bad_fcs) fcs[$urandom_range(0, 31)] ^= 1'b1;
        for (int i = 0; i < 4; i++) frame_bytes.push_back(fcs[8 * i +: 8]);
    endfunction

    function automatic void build_noise(int n);
        frame_bytes.delete();
        repeat (n) frame_bytes.push_back(8'($urandom));
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        int unsigned gap;
        gap = src_fast ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        s_last <= last;
        do @(posedge i_clk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_station(logic [47:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        station = v;
    endtask

    task automatic random_frame();
        int unsigned pick;
        int unsigned k;
        int unsigned keep;
        logic [47:0] dst;
        logic [15:0] etype;
        src_fast = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            build_noise($urandom_range(1, 30));
        end else begin
            case ($urandom_range(0, 5))
                0, 1: dst = station;
                2: dst = '1;
                3: dst = {16'($urandom), $urandom};
                default: dst = station ^ (48'd1 << $urandom_range(0, 47));
            endcase
            k = $urandom_range(0, 9);
            etype = (k < 7) ? known_types[k] : ((k == 7) ? 16'hFFFF : 16'($urandom));
            build_frame(dst, etype, $urandom_range(0, 22), $urandom_range(0, 6) == 0);
            if (pick < 30) begin
                keep = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
            end
        end
        send_frame();
    endtask

    initial begin
        bit fast;
        int unsigned gap;
        fast = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) fast = !fast;
            if (hold_req != hold_done) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_done++;
            end else begin
                gap = fast ? 0 : $urandom_range(0, 15);
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
        end
    end

    initial begin
        logic [47:0] phase_station[4];
        int unsigned stop_at;
        phase_station = '{{16'($urandom), $urandom}, '1, '0, {16'($urandom), $urandom}};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The station address is zero out of reset.
        build_frame('1, C_TYPE_ARP, 0, 1'b0);
        send_frame();
        build_frame('0, C_TYPE_IPV4, 3, 1'b0);
        send_frame();
        build_frame(48'h0000_0000_0001, C_TYPE_IPV6, 2, 1'b0);
        send_frame();
        build_frame('1, 16'h0000, 1, 1'b1);
        send_frame();
        build_noise(17);
        send_frame();
        build_noise(1);
        send_frame();

        set_station('1);
        build_frame('1, C_TYPE_PPP, 0, 1'b0);
        send_frame();

        set_station({16'($urandom), $urandom});
        build_frame(station, C_TYPE_RARP, 4, 1'b0);
        send_frame();
        build_frame(station, C_TYPE_SNMP, 1, 1'b0);
        send_frame();
        build_frame(station, C_TYPE_IPX, 0, 1'b0);
        send_frame();
        build_frame(station, 16'hFFFF, 2, 1'b1);
        send_frame();
        build_frame(station ^ 48'h1, C_TYPE_IPV4, 0, 1'b0);
        send_frame();

        for (int p = 0; p < 4; p++) begin
            set_station(phase_station[p]);
            if (p == 1) begin
                hold_req++;
                src_fast = 1'b1;
                repeat (10) begin
                    build_frame(station, C_TYPE_IPV4, $urandom_range(0, 4), 1'b0);
                    send_frame();
                end
            end
            stop_at = bytes_sent + 150;
            while (bytes_sent < stop_at) random_frame();
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
